@@ sv/rrdsp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrdsp_pkg
// Shared constants, the per-set row layout and row helper functions for the
// RRIP replacement block with dead-block and stream awareness.
// ----------------------------------------------------------------------------
package rrdsp_pkg;

  localparam int NUM_SETS   = 2048;
  localparam int NUM_WAYS   = 16;
  localparam int WINDOW_LEN = 8;

  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = 4;
  localparam int PTR_W   = $clog2(WINDOW_LEN);
  localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
  localparam int ADDR_W  = 64;
  // Epoch must not wrap between two visits of the sweeper to a set.
  localparam int EPOCH_W = SET_W + 2;

  localparam logic [1:0] RRPV_TOP = 2'd3;
  localparam logic [1:0] DEAD_TOP = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_DEAD_THR   = 2'd0;
  localparam logic [1:0] CFG_STREAM_THR = 2'd1;
  localparam logic [1:0] CFG_DECAY      = 2'd2;

  // One memory row holds all state of one set.
  typedef struct packed {
    logic [NUM_WAYS-1:0][1:0]   rrpv;
    logic [NUM_WAYS-1:0][1:0]   dead;
    logic [EPOCH_W-1:0]         epoch;
    logic [ADDR_W-1:0]          prev_addr;
    logic [WINDOW_LEN-1:0][7:0] win;
    logic [PTR_W-1:0]           ptr;
    logic                       flag;
  } row_t;

  // Row contents after reset.
  function automatic row_t init_row();
    row_t r;
    r = '0;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.rrpv[w] = RRPV_TOP;
    end
    return r;
  endfunction

  // Apply the dead-counter decays that happened since the row was last stamped.
  function automatic row_t age_dead(row_t r, logic [EPOCH_W-1:0] now);
    row_t               o;
    logic [EPOCH_W-1:0] diff;
    logic [1:0]         dec;
    o    = r;
    diff = now - r.epoch;
    dec  = (diff >= EPOCH_W'(3)) ? 2'd3 : diff[1:0];
    for (int w = 0; w < NUM_WAYS; w++) begin
      o.dead[w] = (r.dead[w] > dec) ? (r.dead[w] - dec) : 2'd0;
    end
    o.epoch = now;
    return o;
  endfunction

endpackage

@@ sv/rrip_replacement_with_dead_and_stream_top.sv @@
// ----------------------------------------------------------------------------
// rrip_replacement_with_dead_and_stream_top
// Flow: the set row of an accepted item is read through the registered read
//   port, then the execute state writes the row back and registers the result,
//   waiting while an earlier result is stalled. A new item is taken only after
//   the read-modify-write and one background decay-sweep write of another set row.
// Reset: a clearing pass over all 2048 set rows initializes the set row memory;
//   inputs stall during it, configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module rrip_replacement_with_dead_and_stream_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [rrdsp_pkg::SET_W-1:0]   set_index_i,
  input  logic [rrdsp_pkg::WAY_W-1:0]   way_index_i,
  input  logic [rrdsp_pkg::ADDR_W-1:0]  phys_address_i,
  input  logic                          was_hit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrdsp_pkg::WAY_W-1:0]   victim_way_o,
  output logic                          stream_detected_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_EXEC = 2'd2;
  localparam logic [1:0] ST_SWP  = 2'd3;

  logic [1:0]                       state_q, state_d;
  logic [rrdsp_pkg::SET_W-1:0]      clr_cnt_q;
  logic [rrdsp_pkg::SET_W-1:0]      sweep_q;
  logic [rrdsp_pkg::EPOCH_W-1:0]    epoch_q;
  logic [15:0]                      upd_cnt_q;
  logic [1:0]                       dead_thr_q;
  logic [3:0]                       stream_thr_q;
  logic [15:0]                      decay_q;
  logic                             cmd_q, hit_q;
  logic [rrdsp_pkg::SET_W-1:0]      set_q;
  logic [rrdsp_pkg::WAY_W-1:0]      way_q;
  logic [rrdsp_pkg::ADDR_W-1:0]     addr_q;
  logic                             out_valid_q;
  logic [rrdsp_pkg::WAY_W-1:0]      victim_q;
  logic                             stream_q;
  logic                             fwd_q;
  rrdsp_pkg::row_t                  fwd_row_q;
  rrdsp_pkg::row_t                  rdata_q;
  rrdsp_pkg::row_t                  mem [rrdsp_pkg::NUM_SETS];

  logic                             in_fire, proceed, decay;
  logic [16:0]                      cnt_next, period;
  logic [rrdsp_pkg::EPOCH_W-1:0]    epoch_now;
  rrdsp_pkg::row_t                  new_row, sweep_row;
  logic [rrdsp_pkg::WAY_W-1:0]      victim;
  logic                             flag;
  logic                             re, we;
  logic [rrdsp_pkg::SET_W-1:0]      raddr, waddr;
  rrdsp_pkg::row_t                  wdata;

  assign in_stall_o        = (state_q != ST_IDLE);
  assign in_fire           = in_valid_i && !in_stall_o;
  assign proceed           = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign victim_way_o      = victim_q;
  assign stream_detected_o = stream_q;

  // Global decay counter; a decay advances the epoch.
  assign cnt_next  = {1'b0, upd_cnt_q} + 17'd1;
  assign period    = (decay_q == '0) ? 17'h10000 : {1'b0, decay_q};
  assign decay     = cmd_q && (cnt_next >= period);
  assign epoch_now = epoch_q + rrdsp_pkg::EPOCH_W'(decay);

  rrdsp_row_logic u_row_logic (
    .row_i        (rdata_q),
    .cmd_i        (cmd_q),
    .way_i        (way_q),
    .addr_i       (addr_q),
    .hit_i        (hit_q),
    .dead_thr_i   (dead_thr_q),
    .stream_thr_i (stream_thr_q),
    .epoch_i      (epoch_now),
    .row_o        (new_row),
    .victim_o     (victim),
    .flag_o       (flag)
  );

  // The sweep row comes from the item write when both name the same set.
  assign sweep_row = rrdsp_pkg::age_dead(fwd_q ? fwd_row_q : rdata_q, epoch_q);

  // Memory port selection.
  always_comb begin
    re    = 1'b0;
    raddr = set_index_i;
    we    = 1'b0;
    waddr = clr_cnt_q;
    wdata = rrdsp_pkg::init_row();
    case (state_q)
      ST_CLR: begin
        we = 1'b1;
      end
      ST_IDLE: begin
        re = in_fire;
      end
      ST_EXEC: begin
        re    = proceed;
        raddr = sweep_q;
        we    = proceed;
        waddr = set_q;
        wdata = new_row;
      end
      ST_SWP: begin
        we    = 1'b1;
        waddr = sweep_q;
        wdata = sweep_row;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // Set row memory, one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLR:  if (clr_cnt_q == '1) state_d = ST_IDLE;
      ST_IDLE: if (in_fire) state_d = ST_EXEC;
      ST_EXEC: if (proceed) state_d = ST_SWP;
      ST_SWP:  state_d = ST_IDLE;
      default: state_d = ST_CLR;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      clr_cnt_q    <= '0;
      sweep_q      <= '0;
      epoch_q      <= '0;
      upd_cnt_q    <= '0;
      dead_thr_q   <= 2'd2;
      stream_thr_q <= 4'd6;
      decay_q      <= 16'd4096;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (state_q == ST_SWP) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (proceed && cmd_q) begin
        epoch_q   <= epoch_now;
        upd_cnt_q <= decay ? 16'd0 : cnt_next[15:0];
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          rrdsp_pkg::CFG_DEAD_THR:   dead_thr_q   <= cfg_data_i[1:0];
          rrdsp_pkg::CFG_STREAM_THR: stream_thr_q <= cfg_data_i[3:0];
          rrdsp_pkg::CFG_DECAY:      decay_q      <= cfg_data_i;
          default:                   decay_q      <= decay_q;
        endcase
      end
      if (proceed) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q  <= cmd_i;
      set_q  <= set_index_i;
      way_q  <= way_index_i;
      addr_q <= phys_address_i;
      hit_q  <= was_hit_i;
    end
    if (proceed) begin
      victim_q  <= cmd_q ? '0 : victim;
      stream_q  <= flag;
      fwd_q     <= (sweep_q == set_q);
      fwd_row_q <= new_row;
    end
  end

endmodule

@@ sv/rrdsp_row_logic.sv @@
// ----------------------------------------------------------------------------
// rrdsp_row_logic
// Combinational modify step on one set row: victim search with aging for a
// find, stream detector and way update for an update.
// ----------------------------------------------------------------------------
module rrdsp_row_logic (
  input  rrdsp_pkg::row_t                row_i,
  input  logic                           cmd_i,
  input  logic [rrdsp_pkg::WAY_W-1:0]    way_i,
  input  logic [rrdsp_pkg::ADDR_W-1:0]   addr_i,
  input  logic                           hit_i,
  input  logic [1:0]                     dead_thr_i,
  input  logic [3:0]                     stream_thr_i,
  input  logic [rrdsp_pkg::EPOCH_W-1:0]  epoch_i,
  output rrdsp_pkg::row_t                row_o,
  output logic [rrdsp_pkg::WAY_W-1:0]    victim_o,
  output logic                           flag_o
);

  rrdsp_pkg::row_t                 aged;
  rrdsp_pkg::row_t                 upd;
  rrdsp_pkg::row_t                 fnd;
  logic [1:0]                      top;
  logic [rrdsp_pkg::ADDR_W-1:0]    diff;
  logic [7:0]                      delta;
  logic [rrdsp_pkg::CNT_W-1:0]     pos;
  logic [rrdsp_pkg::CNT_W-1:0]     neg;
  logic                            new_flag;
  logic [1:0]                      dead_n;

  assign aged = rrdsp_pkg::age_dead(row_i, epoch_i);
  assign diff = addr_i - row_i.prev_addr;

  // Find: age the set so that the oldest way reaches the top, pick the lowest.
  always_comb begin
    fnd      = aged;
    top      = '0;
    victim_o = '0;
    for (int w = 0; w < rrdsp_pkg::NUM_WAYS; w++) begin
      if (row_i.rrpv[w] > top) begin
        top = row_i.rrpv[w];
      end
    end
    for (int w = 0; w < rrdsp_pkg::NUM_WAYS; w++) begin
      fnd.rrpv[w] = row_i.rrpv[w] + (rrdsp_pkg::RRPV_TOP - top);
    end
    for (int w = rrdsp_pkg::NUM_WAYS - 1; w >= 0; w--) begin
      if (fnd.rrpv[w] == rrdsp_pkg::RRPV_TOP) begin
        victim_o = rrdsp_pkg::WAY_W'(w);
      end
    end
  end

  // Update: stream window, then hit or fill of the addressed way.
  always_comb begin
    upd   = aged;
    delta = (row_i.prev_addr != '0) ? diff[13:6] : 8'h00;
    upd.win[row_i.ptr] = delta;
    upd.ptr       = row_i.ptr + 1'b1;
    upd.prev_addr = addr_i;
    pos = '0;
    neg = '0;
    for (int i = 0; i < rrdsp_pkg::WINDOW_LEN; i++) begin
      if (upd.win[i] == 8'h01) begin
        pos = pos + 1'b1;
      end else if (upd.win[i] == 8'hFF) begin
        neg = neg + 1'b1;
      end
    end
    new_flag = (32'(pos) >= 32'(stream_thr_i)) || (32'(neg) >= 32'(stream_thr_i));
    upd.flag = new_flag;
    dead_n   = (aged.dead[way_i] < rrdsp_pkg::DEAD_TOP) ? aged.dead[way_i] + 2'd1
                                                        : aged.dead[way_i];
    if (hit_i) begin
      upd.rrpv[way_i] = 2'd0;
      upd.dead[way_i] = 2'd0;
    end else begin
      upd.dead[way_i] = dead_n;
      if (dead_n >= dead_thr_i) begin
        upd.rrpv[way_i] = new_flag ? 2'd3 : 2'd2;
      end else begin
        upd.rrpv[way_i] = 2'd0;
      end
    end
  end

  assign row_o  = cmd_i ? upd : fnd;
  assign flag_o = cmd_i ? upd.flag : row_i.flag;

endmodule

@@ sv/rrdsp_checker.sv @@
// ----------------------------------------------------------------------------
// rrdsp_checker
// Port-level checks of the replacement block, bound to its top level.
// ----------------------------------------------------------------------------
module rrdsp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          cmd_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [rrdsp_pkg::WAY_W-1:0]   victim_way_o,
  input logic                          stream_detected_o
);

  // A waiting result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(victim_way_o)
                                      && $stable(stream_detected_o)))
    else $error("stalled result changed");

  // Items are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item taken while one is in work");

  // An update on a free output yields a result with a zero victim.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i && !out_valid_o) |-> ##2
      (out_valid_o && (victim_way_o == '0)))
    else $error("update result missing or victim not zero");

endmodule

bind rrip_replacement_with_dead_and_stream_top rrdsp_checker u_rrdsp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .cmd_i             (cmd_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .victim_way_o      (victim_way_o),
  .stream_detected_o (stream_detected_o)
);

@@ tb/rrip_replacement_with_dead_and_stream_top_tb.sv @@
// ----------------------------------------------------------------------------
// rrip_replacement_with_dead_and_stream_top_tb
// Self-checking bench for the RRIP replacement block. A queue of victim
// queries and access updates feeds a clocked driver. A local predictor
// computes each expected victim and stream flag at input transfer, and a
// clocked monitor compares every output transfer against the oldest
// expectation. Several register settings are exercised, including extremes.
// ----------------------------------------------------------------------------
module rrip_replacement_with_dead_and_stream_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CMD_FIND   = 0;
  localparam int CMD_UPDATE = 1;
  localparam int LIMIT      = 600000;

  typedef struct {
    logic                         cmd;
    logic [rrdsp_pkg::SET_W-1:0]  set_idx;
    logic [rrdsp_pkg::WAY_W-1:0]  way;
    logic [rrdsp_pkg::ADDR_W-1:0] addr;
    logic                         hit;
  } access_t;

  typedef struct {
    logic [rrdsp_pkg::WAY_W-1:0] victim;
    logic                        stream;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic cmd_i = 1'b0;
  logic [rrdsp_pkg::SET_W-1:0] set_index_i = '0;
  logic [rrdsp_pkg::WAY_W-1:0] way_index_i = '0;
  logic [rrdsp_pkg::ADDR_W-1:0] phys_address_i = '0;
  logic was_hit_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [rrdsp_pkg::WAY_W-1:0] victim_way_o;
  logic stream_detected_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  rrip_replacement_with_dead_and_stream_top u_top (.*);

  // Policy state mirror.
  logic [1:0]                   rrpv_m [rrdsp_pkg::NUM_SETS][rrdsp_pkg::NUM_WAYS];
  logic [1:0]                   dead_m [rrdsp_pkg::NUM_SETS][rrdsp_pkg::NUM_WAYS];
  int                           stamp_m [rrdsp_pkg::NUM_SETS];
  logic [rrdsp_pkg::ADDR_W-1:0] last_m [rrdsp_pkg::NUM_SETS];
  logic [7:0]                   win_m [rrdsp_pkg::NUM_SETS][rrdsp_pkg::WINDOW_LEN];
  logic [rrdsp_pkg::PTR_W-1:0]  ptr_m [rrdsp_pkg::NUM_SETS];
  logic                         flag_m [rrdsp_pkg::NUM_SETS];
  int                           upd_count;
  int                           decay_total;
  logic [1:0]                   dead_thr;
  logic [3:0]                   stream_thr;
  logic [15:0]                  decay_per;

  access_t  pending_accesses[$];
  verdict_t expected_verdicts[$];
  access_t  cur;
  bit       taken;
  bit       quiet;
  bit       long_hold;
  int       in_gap;
  int       out_gap;
  int       hold_cnt;
  int       failures;
  int       cycles;
  logic [rrdsp_pkg::ADDR_W-1:0] stream_addr [8];

  // Advance the replacement state by one access and return its result.
  function automatic verdict_t apply_access(access_t a);
    verdict_t                     v;
    int                           top;
    int                           pos;
    int                           neg;
    int                           nxt;
    int                           period;
    int                           diff;
    logic [rrdsp_pkg::ADDR_W-1:0] d;
    logic [7:0]                   delta;
    v.victim = '0;
    if (a.cmd == CMD_FIND) begin
      top = 0;
      for (int w = 0; w < rrdsp_pkg::NUM_WAYS; w++)
        if (rrpv_m[a.set_idx][w] > top) top = rrpv_m[a.set_idx][w];
      for (int w = 0; w < rrdsp_pkg::NUM_WAYS; w++) rrpv_m[a.set_idx][w] += 2'(3 - top);
      for (int w = rrdsp_pkg::NUM_WAYS - 1; w >= 0; w--)
        if (rrpv_m[a.set_idx][w] == rrdsp_pkg::RRPV_TOP) v.victim = rrdsp_pkg::WAY_W'(w);
    end else begin
      // Stream detector: signed line delta into the set's window.
      delta = '0;
      if (last_m[a.set_idx] != '0) begin
        d = (a.addr - last_m[a.set_idx]) >> 6;
        delta = d[7:0];
      end
      win_m[a.set_idx][ptr_m[a.set_idx]] = delta;
      ptr_m[a.set_idx]++;
      last_m[a.set_idx] = a.addr;
      pos = 0;
      neg = 0;
      for (int i = 0; i < rrdsp_pkg::WINDOW_LEN; i++) begin
        if (win_m[a.set_idx][i] == 8'h01) pos++;
        else if (win_m[a.set_idx][i] == 8'hFF) neg++;
      end
      flag_m[a.set_idx] = (pos >= stream_thr) || (neg >= stream_thr);
      // Global decay, applied lazily per set.
      period = (decay_per == 0) ? 65536 : decay_per;
      nxt = upd_count + 1;
      if (nxt >= period) begin
        upd_count = 0;
        decay_total++;
      end else begin
        upd_count = nxt;
      end
      diff = decay_total - stamp_m[a.set_idx];
      for (int w = 0; w < rrdsp_pkg::NUM_WAYS; w++)
        dead_m[a.set_idx][w] = (dead_m[a.set_idx][w] > diff) ?
                               2'(dead_m[a.set_idx][w] - diff) : 2'd0;
      stamp_m[a.set_idx] = decay_total;
      if (a.hit) begin
        rrpv_m[a.set_idx][a.way] = 0;
        dead_m[a.set_idx][a.way] = 0;
      end else begin
        if (dead_m[a.set_idx][a.way] < rrdsp_pkg::DEAD_TOP) dead_m[a.set_idx][a.way]++;
        if (dead_m[a.set_idx][a.way] >= dead_thr)
          rrpv_m[a.set_idx][a.way] = flag_m[a.set_idx] ? 2'd3 : 2'd2;
        else
          rrpv_m[a.set_idx][a.way] = 0;
      end
    end
    v.stream = flag_m[a.set_idx];
    return v;
  endfunction

  function automatic access_t make_access(bit c, int s, int w,
                                          logic [rrdsp_pkg::ADDR_W-1:0] ad, bit h);
    access_t a;
    a.cmd = c;
    a.set_idx = rrdsp_pkg::SET_W'(s);
    a.way = rrdsp_pkg::WAY_W'(w);
    a.addr = ad;
    a.hit = h;
    return a;
  endfunction

  // Clock and cycle limit.
  initial forever #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Timeout at %0t", $time);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Input side: predict at transfer.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_verdicts.push_back(apply_access(cur));
      taken = 1'b1;
    end
  end

  // Driver: presents queued accesses with random gaps.
  always @(negedge clk_i) begin
    logic nv;
    nv = 1'b0;
    if (in_valid_i && !taken) begin
      nv = 1'b1;
    end else if (in_gap > 0) begin
      in_gap--;
    end else if (pending_accesses.size() > 0) begin
      if (!quiet && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 15);
      end else begin
        cur = pending_accesses.pop_front();
        cmd_i <= cur.cmd;
        set_index_i <= cur.set_idx;
        way_index_i <= cur.way;
        phys_address_i <= cur.addr;
        was_hit_i <= cur.hit;
        nv = 1'b1;
      end
    end
    taken = 1'b0;
    in_valid_i <= nv;
  end

  // Receiver stall: random bursts plus one long hold-off.
  always @(negedge clk_i) begin
    logic ns;
    ns = 1'b0;
    if (long_hold) begin
      ns = 1'b1;
      hold_cnt++;
      if (hold_cnt >= 300) long_hold = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      ns = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap = $urandom_range(0, 15);
      ns = 1'b1;
    end
    out_stall_i <= ns;
  end

  // Monitor: compares each output transfer with the oldest expectation.
  always @(posedge clk_i) begin
    verdict_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result victim=%0d stream=%0d", $time, victim_way_o,
                 stream_detected_o);
        failures++;
      end else begin
        e = expected_verdicts.pop_front();
        if (victim_way_o !== e.victim) begin
          $display("%0t: victim_way expected %0d actual %0d", $time, e.victim, victim_way_o);
          failures++;
        end
        if (stream_detected_o !== e.stream) begin
          $display("%0t: stream_detected expected %0d actual %0d", $time, e.stream,
                   stream_detected_o);
          failures++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      rrdsp_pkg::CFG_DEAD_THR:   dead_thr = val[1:0];
      rrdsp_pkg::CFG_STREAM_THR: stream_thr = val[3:0];
      default:                   decay_per = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() > 0 || in_valid_i || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Random traffic: mostly unit-stride runs on a few sets, plus noise.
  task automatic queue_random(int n);
    int k;
    int s;
    int dir;
    int len;
    k = 0;
    while (k < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          s = $urandom_range(0, 7);
          dir = $urandom_range(0, 1) ? 64 : -64;
          len = $urandom_range(4, 12);
          for (int i = 0; i < len; i++) begin
            stream_addr[s] += dir;
            pending_accesses.push_back(make_access(CMD_UPDATE, s, $urandom_range(0, 15),
                                       stream_addr[s], $urandom_range(0, 1)));
            if ($urandom_range(0, 2) == 0) begin
              pending_accesses.push_back(make_access(CMD_FIND, s, 0, 0, 0));
              k++;
            end
          end
          k += len;
        end
        4, 5: begin
          s = $urandom_range(0, 7);
          for (int i = 0; i < 4; i++)
            pending_accesses.push_back(make_access(CMD_UPDATE, s, $urandom_range(0, 3),
                                       stream_addr[s] + 64 * $urandom_range(0, 3), 1'b0));
          pending_accesses.push_back(make_access(CMD_FIND, s, 0, 0, 0));
          k += 5;
        end
        default: begin
          pending_accesses.push_back(make_access($urandom_range(0, 1),
                                     $urandom_range(0, 1) ? $urandom_range(0, 2047)
                                                          : $urandom_range(0, 7),
                                     $urandom_range(0, 15), {$urandom, $urandom},
                                     $urandom_range(0, 1)));
          k++;
        end
      endcase
    end
  endtask

  // Sequence: reset, directed accesses, then random phases under new settings.
  initial begin
    logic [15:0] cfgs [6][3];
    cfgs = '{'{16'd0, 16'd0, 16'd1}, '{16'd3, 16'd8, 16'd65535}, '{16'd1, 16'd15, 16'd0},
             '{16'd2, 16'd3, 16'd5}, '{16'd3, 16'd1, 16'd2}, '{16'd2, 16'd6, 16'd7}};
    failures = 0;
    cycles = 0;
    quiet = 1'b0;
    long_hold = 1'b0;
    hold_cnt = 0;
    in_gap = 0;
    out_gap = 0;
    taken = 1'b0;
    upd_count = 0;
    decay_total = 0;
    dead_thr = 2;
    stream_thr = 6;
    decay_per = 4096;
    for (int s = 0; s < rrdsp_pkg::NUM_SETS; s++) begin
      stamp_m[s] = 0;
      last_m[s] = '0;
      ptr_m[s] = '0;
      flag_m[s] = 1'b0;
      for (int w = 0; w < rrdsp_pkg::NUM_WAYS; w++) begin
        rrpv_m[s][w] = rrdsp_pkg::RRPV_TOP;
        dead_m[s][w] = '0;
      end
      for (int i = 0; i < rrdsp_pkg::WINDOW_LEN; i++) win_m[s][i] = '0;
    end
    for (int s = 0; s < 8; s++) stream_addr[s] = {$urandom, $urandom};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset victims, zero address, extremes, dead fills, both strides.
    pending_accesses.push_back(make_access(CMD_FIND, 0, 0, 0, 0));
    pending_accesses.push_back(make_access(CMD_FIND, 2047, 15, '1, 1));
    pending_accesses.push_back(make_access(CMD_UPDATE, 2047, 15, '0, 1));
    pending_accesses.push_back(make_access(CMD_UPDATE, 2047, 0, '1, 0));
    pending_accesses.push_back(make_access(CMD_FIND, 2047, 0, 0, 0));
    for (int i = 0; i < 3; i++)
      pending_accesses.push_back(make_access(CMD_UPDATE, 3, 5, 64'h1000 + i * 4096, 0));
    pending_accesses.push_back(make_access(CMD_FIND, 3, 0, 0, 0));
    for (int i = 1; i <= 7; i++)
      pending_accesses.push_back(make_access(CMD_UPDATE, 1, i, 64'h4000 + i * 64, 0));
    pending_accesses.push_back(make_access(CMD_FIND, 1, 0, 0, 0));
    for (int i = 1; i <= 7; i++)
      pending_accesses.push_back(make_access(CMD_UPDATE, 2, 9, 64'h9000 - i * 64, 0));
    queue_random(260);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      write_reg(rrdsp_pkg::CFG_DEAD_THR, cfgs[p][0]);
      write_reg(rrdsp_pkg::CFG_STREAM_THR, cfgs[p][1]);
      write_reg(rrdsp_pkg::CFG_DECAY, cfgs[p][2]);
      if (p == 1) begin
        hold_cnt = 0;
        long_hold = 1'b1;
      end
      if (p == 5) quiet = 1'b1;
      queue_random(220);
      wait_drained();
    end

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
